// ===== rtl/bspg_pkg.sv =====
package bspg_pkg;

   localparam int NUM_SIDES    = 8;
   localparam int HALF_COUNT   = 2 * NUM_SIDES;
   localparam int IDX_W        = (NUM_SIDES > 1) ? $clog2(NUM_SIDES) : 1;
   // k runs 0..HALF_COUNT-1, k+1 must fit as well
   localparam int K_W          = $clog2(HALF_COUNT) + 1;
   localparam int SECTOR_W     = 5;
   localparam int TRIG_W       = 18;
   localparam int SERIES_TERMS = 12;

   localparam longint Q30_ONE = longint'(1) << 30;
   localparam longint PI_Q30  = 64'sd3373259426;

   localparam logic signed [35:0] SAT_MAX = 36'sd2147483647;
   localparam logic signed [35:0] SAT_MIN = -36'sd2147483648;

   typedef logic signed [31:0]       coord_type;
   typedef logic signed [TRIG_W-1:0] trig_type;
   typedef logic [SECTOR_W-1:0]      sector_type;

   typedef struct packed {
      coord_type track_x;
      coord_type track_y;
      coord_type track_z;
      coord_type point_local_x;
      coord_type point_local_y;
      coord_type point_local_z;
      logic      last_point;
   } point_type;

   typedef struct packed {
      point_type  point;
      sector_type sector;
   } sec_item_type;

   typedef struct packed {
      coord_type  global_x;
      coord_type  global_y;
      coord_type  global_z;
      sector_type sector;
      logic       last_out;
   } rsp_item_type;

   // Shift-and-subtract quotient of two non-negative elaboration-time values.
   function automatic longint udiv_q(longint n, longint d);
      longint q;
      longint r;
      int     b;
      q = 0;
      r = 0;
      for (b = 62; b >= 0; b--) begin
         r = (r <<< 1) | ((n >>> b) & longint'(1));
         if (r >= d) begin
            r = r - d;
            q = q | (longint'(1) <<< b);
         end
      end
      return q;
   endfunction

   // Truncated Taylor series in Q2.30 on an angle within one quadrant.
   function automatic longint series_q30(longint a, bit want_sin);
      longint a2;
      longint t;
      longint acc;
      int     k;
      a2 = (a * a) >>> 30;
      if (want_sin) begin
         t   = a;
         acc = a;
         for (k = 1; k <= SERIES_TERMS; k++) begin
            t   = udiv_q((t * a2) >>> 30, longint'((2 * k) * (2 * k + 1)));
            acc = k[0] ? acc - t : acc + t;
         end
      end else begin
         t   = Q30_ONE;
         acc = t;
         for (k = 1; k <= SERIES_TERMS; k++) begin
            t   = udiv_q((t * a2) >>> 30, longint'((2 * k - 1) * (2 * k)));
            acc = k[0] ? acc - t : acc + t;
         end
      end
      return acc;
   endfunction

   // Direction of angle j*pi/NUM_SIDES in Q2.30.
   function automatic longint dir_q30(int j, bit want_sin);
      int     quad;
      int     rem;
      longint a;
      longint c;
      longint s;
      longint r;
      quad = int'(udiv_q(longint'(2 * j), longint'(NUM_SIDES)));
      rem  = 2 * j - quad * NUM_SIDES;
      a    = udiv_q(longint'(rem) * PI_Q30, longint'(2 * NUM_SIDES));
      c    = series_q30(a, 1'b0);
      s    = series_q30(a, 1'b1);
      unique case (quad[1:0])
         2'd0:    r = want_sin ? s : c;
         2'd1:    r = want_sin ? c : -s;
         2'd2:    r = want_sin ? -s : -c;
         default: r = want_sin ? -c : s;
      endcase
      return r;
   endfunction

   // Round half up from Q2.30 to Q1.16.
   function automatic longint q30_to_q16(longint v);
      return ((v + Q30_ONE + (longint'(1) << 13)) >>> 14) - (longint'(1) << 16);
   endfunction

   function automatic coord_type sat32(logic signed [35:0] v);
      coord_type r;
      if (v > SAT_MAX) begin
         r = coord_type'(SAT_MAX[31:0]);
      end else if (v < SAT_MIN) begin
         r = coord_type'(SAT_MIN[31:0]);
      end else begin
         r = coord_type'(v[31:0]);
      end
      return r;
   endfunction

endpackage

// ===== rtl/bspg_req_if.sv =====
interface bspg_req_if import bspg_pkg::*; ();
   logic      valid;
   logic      ready;
   coord_type track_x;
   coord_type track_y;
   coord_type track_z;
   coord_type point_local_x;
   coord_type point_local_y;
   coord_type point_local_z;
   logic      last_point;

   modport source (
      output valid, track_x, track_y, track_z,
             point_local_x, point_local_y, point_local_z, last_point,
      input  ready
   );

   modport sink (
      input  valid, track_x, track_y, track_z,
             point_local_x, point_local_y, point_local_z, last_point,
      output ready
   );
endinterface

// ===== rtl/bspg_rsp_if.sv =====
interface bspg_rsp_if import bspg_pkg::*; ();
   logic       valid;
   logic       ready;
   coord_type  global_x;
   coord_type  global_y;
   coord_type  global_z;
   sector_type sector;
   logic       last_out;

   modport source (
      output valid, global_x, global_y, global_z, sector, last_out,
      input  ready
   );

   modport sink (
      input  valid, global_x, global_y, global_z, sector, last_out,
      output ready
   );
endinterface

// ===== rtl/bspg_sector.sv =====
module bspg_sector import bspg_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         in_valid,
   output logic         in_ready,
   input  point_type    in_point,
   output logic         out_valid,
   input  logic         out_ready,
   output sec_item_type out_item
);

   logic s1_adv, s2_adv, s3_adv, s4_adv;

   logic               s1_valid_ff;
   logic               s1_flip_ff, s1_zero_ff;
   logic signed [32:0] s1_xf_ff, s1_yf_ff;
   point_type          s1_point_ff;

   logic               s2_valid_ff;
   logic               s2_flip_ff, s2_zero_ff;
   logic signed [64:0] s2_pc_ff [1:NUM_SIDES-1];
   logic signed [64:0] s2_ps_ff [1:NUM_SIDES-1];
   point_type          s2_point_ff;

   logic                   s3_valid_ff;
   logic                   s3_flip_ff, s3_zero_ff;
   logic [NUM_SIDES-1:1]   s3_ge_in, s3_ge_ff;
   point_type              s3_point_ff;

   logic         out_valid_ff;
   sec_item_type out_item_ff;

   logic               s1_flip_in, s1_zero_in;
   logic signed [32:0] x_ext, y_ext, s1_xf_in, s1_yf_in;
   logic [K_W-1:0]     k_sum;
   sector_type         sector_in;

   // a stage moves when it is empty or the next one moves
   assign s4_adv   = !out_valid_ff || out_ready;
   assign s3_adv   = !s3_valid_ff || s4_adv;
   assign s2_adv   = !s2_valid_ff || s3_adv;
   assign s1_adv   = !s1_valid_ff || s2_adv;
   assign in_ready = s1_adv;

   // fold the lower half plane onto the upper one
   always_comb begin
      x_ext      = $signed({in_point.track_x[31], in_point.track_x});
      y_ext      = $signed({in_point.track_y[31], in_point.track_y});
      s1_flip_in = in_point.track_y[31] ||
                   ((in_point.track_y == '0) && in_point.track_x[31]);
      s1_zero_in = (in_point.track_x == '0) && (in_point.track_y == '0);
      s1_xf_in   = s1_flip_in ? -x_ext : x_ext;
      s1_yf_in   = s1_flip_in ? -y_ext : y_ext;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         s3_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         if (s1_adv) begin
            s1_valid_ff <= in_valid;
         end
         if (s2_adv) begin
            s2_valid_ff <= s1_valid_ff;
         end
         if (s3_adv) begin
            s3_valid_ff <= s2_valid_ff;
         end
         if (s4_adv) begin
            out_valid_ff <= s3_valid_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (s1_adv) begin
         s1_flip_ff  <= s1_flip_in;
         s1_zero_ff  <= s1_zero_in;
         s1_xf_ff    <= s1_xf_in;
         s1_yf_ff    <= s1_yf_in;
         s1_point_ff <= in_point;
      end
      if (s2_adv) begin
         s2_flip_ff  <= s1_flip_ff;
         s2_zero_ff  <= s1_zero_ff;
         s2_point_ff <= s1_point_ff;
      end
      if (s3_adv) begin
         s3_flip_ff  <= s2_flip_ff;
         s3_zero_ff  <= s2_zero_ff;
         s3_ge_ff    <= s3_ge_in;
         s3_point_ff <= s2_point_ff;
      end
      if (s4_adv) begin
         out_item_ff.point  <= s3_point_ff;
         out_item_ff.sector <= sector_in;
      end
   end

   // one cross product against each inner half-sector boundary
   for (genvar j = 1; j < NUM_SIDES; j++) begin : g_cross
      localparam logic signed [31:0] DIR_COS = 32'(dir_q30(j, 1'b0));
      localparam logic signed [31:0] DIR_SIN = 32'(dir_q30(j, 1'b1));
      logic signed [64:0] diff;

      always_ff @(posedge clock) begin
         if (s2_adv) begin
            s2_pc_ff[j] <= DIR_COS * s1_yf_ff;
            s2_ps_ff[j] <= DIR_SIN * s1_xf_ff;
         end
      end

      assign diff        = s2_pc_ff[j] - s2_ps_ff[j];
      assign s3_ge_in[j] = !diff[64];
   end

   // count boundaries passed, then merge the two halves around sector 0
   always_comb begin
      k_sum = s3_flip_ff ? K_W'(NUM_SIDES) : '0;
      for (int j = 1; j < NUM_SIDES; j++) begin
         k_sum = k_sum + K_W'(s3_ge_ff[j]);
      end
      if (s3_zero_ff || (k_sum == '0) || (k_sum == K_W'(HALF_COUNT - 1))) begin
         sector_in = '0;
      end else begin
         sector_in = SECTOR_W'((k_sum + K_W'(1)) >> 1);
      end
   end

   assign out_valid = out_valid_ff;
   assign out_item  = out_item_ff;

endmodule

// ===== rtl/bspg_rotate.sv =====
module bspg_rotate import bspg_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         in_valid,
   output logic         in_ready,
   input  sec_item_type in_item,
   output logic         out_valid,
   input  logic         out_ready,
   output rsp_item_type out_item
);

   trig_type rot_cos_tab [NUM_SIDES];
   trig_type rot_sin_tab [NUM_SIDES];

   logic r1_adv, r2_adv, r3_adv, r4_adv;

   logic         r1_valid_ff;
   trig_type     r1_cos_ff, r1_sin_ff;
   sec_item_type r1_item_ff;

   logic               r2_valid_ff;
   logic signed [49:0] r2_cz_ff, r2_sy_ff, r2_sz_ff, r2_cy_ff;
   sec_item_type       r2_item_ff;

   logic               r3_valid_ff;
   logic signed [34:0] r3_rx_in, r3_ry_in, r3_rx_ff, r3_ry_ff;
   logic signed [32:0] r3_gz_in, r3_gz_ff;
   sec_item_type       r3_item_ff;

   logic         out_valid_ff;
   rsp_item_type out_item_in, out_item_ff;

   logic signed [50:0] sum_x, sum_y;
   logic signed [35:0] gx_sum, gy_sum;
   logic [IDX_W-1:0]   tab_idx;

   for (genvar s = 0; s < NUM_SIDES; s++) begin : g_tab
      assign rot_cos_tab[s] = TRIG_W'(q30_to_q16(dir_q30(2 * s, 1'b0)));
      assign rot_sin_tab[s] = TRIG_W'(q30_to_q16(dir_q30(2 * s, 1'b1)));
   end

   assign r4_adv   = !out_valid_ff || out_ready;
   assign r3_adv   = !r3_valid_ff || r4_adv;
   assign r2_adv   = !r2_valid_ff || r3_adv;
   assign r1_adv   = !r1_valid_ff || r2_adv;
   assign in_ready = r1_adv;

   assign tab_idx = in_item.sector[IDX_W-1:0];

   always_comb begin
      // round half up to 1/256 mm: keep the upper bits after the bias
      sum_x = $signed({r2_cz_ff[49], r2_cz_ff}) - $signed({r2_sy_ff[49], r2_sy_ff})
              + 51'sd32768;
      sum_y = $signed({r2_sz_ff[49], r2_sz_ff}) + $signed({r2_cy_ff[49], r2_cy_ff})
              + 51'sd32768;
      r3_rx_in = sum_x[50:16];
      r3_ry_in = sum_y[50:16];
      r3_gz_in = $signed({r2_item_ff.point.track_z[31], r2_item_ff.point.track_z})
                 - $signed({r2_item_ff.point.point_local_x[31],
                            r2_item_ff.point.point_local_x});
   end

   always_comb begin
      gx_sum = $signed({{4{r3_item_ff.point.track_x[31]}}, r3_item_ff.point.track_x})
               + $signed({r3_rx_ff[34], r3_rx_ff});
      gy_sum = $signed({{4{r3_item_ff.point.track_y[31]}}, r3_item_ff.point.track_y})
               + $signed({r3_ry_ff[34], r3_ry_ff});
      out_item_in.global_x = sat32(gx_sum);
      out_item_in.global_y = sat32(gy_sum);
      out_item_in.global_z = sat32($signed({{3{r3_gz_ff[32]}}, r3_gz_ff}));
      out_item_in.sector   = r3_item_ff.sector;
      out_item_in.last_out = r3_item_ff.point.last_point;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         r1_valid_ff  <= 1'b0;
         r2_valid_ff  <= 1'b0;
         r3_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         if (r1_adv) begin
            r1_valid_ff <= in_valid;
         end
         if (r2_adv) begin
            r2_valid_ff <= r1_valid_ff;
         end
         if (r3_adv) begin
            r3_valid_ff <= r2_valid_ff;
         end
         if (r4_adv) begin
            out_valid_ff <= r3_valid_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (r1_adv) begin
         r1_cos_ff  <= rot_cos_tab[tab_idx];
         r1_sin_ff  <= rot_sin_tab[tab_idx];
         r1_item_ff <= in_item;
      end
      if (r2_adv) begin
         r2_cz_ff   <= r1_cos_ff * r1_item_ff.point.point_local_z;
         r2_sy_ff   <= r1_sin_ff * r1_item_ff.point.point_local_y;
         r2_sz_ff   <= r1_sin_ff * r1_item_ff.point.point_local_z;
         r2_cy_ff   <= r1_cos_ff * r1_item_ff.point.point_local_y;
         r2_item_ff <= r1_item_ff;
      end
      if (r3_adv) begin
         r3_rx_ff   <= r3_rx_in;
         r3_ry_ff   <= r3_ry_in;
         r3_gz_ff   <= r3_gz_in;
         r3_item_ff <= r2_item_ff;
      end
      if (r4_adv) begin
         out_item_ff <= out_item_in;
      end
   end

   assign out_valid = out_valid_ff;
   assign out_item  = out_item_ff;

endmodule

// ===== rtl/barrel_sector_point_to_global.sv =====
// Channel  Direction  Contents
// req_ch   in         track entry position, local space point, last flag
// rsp_ch   out        global point (saturated), sector, last flag copy
//
// One item per cycle sustained while rsp_ch.ready stays high; a result passes
// through 8 register stages (4 of sector search, 4 of rotation and
// saturation) after the edge that takes its item.
// Reset clears only the stage valid bits; the trig tables are constants.
// A stalled output holds its stage; earlier stages keep filling bubbles,
// so req_ch.ready drops only once every stage holds an item.
module barrel_sector_point_to_global import bspg_pkg::*; (
   input logic        clock,
   input logic        reset,
   bspg_req_if.sink   req_ch,
   bspg_rsp_if.source rsp_ch
);

   point_type    req_point;
   logic         sec_valid, sec_ready;
   sec_item_type sec_item;
   rsp_item_type rsp_item;
   logic         rsp_valid;

   assign req_point.track_x       = req_ch.track_x;
   assign req_point.track_y       = req_ch.track_y;
   assign req_point.track_z       = req_ch.track_z;
   assign req_point.point_local_x = req_ch.point_local_x;
   assign req_point.point_local_y = req_ch.point_local_y;
   assign req_point.point_local_z = req_ch.point_local_z;
   assign req_point.last_point    = req_ch.last_point;

   bspg_sector u_sector (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_ch.valid),
      .in_ready  (req_ch.ready),
      .in_point  (req_point),
      .out_valid (sec_valid),
      .out_ready (sec_ready),
      .out_item  (sec_item)
   );

   bspg_rotate u_rotate (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (sec_valid),
      .in_ready  (sec_ready),
      .in_item   (sec_item),
      .out_valid (rsp_valid),
      .out_ready (rsp_ch.ready),
      .out_item  (rsp_item)
   );

   assign rsp_ch.valid    = rsp_valid;
   assign rsp_ch.global_x = rsp_item.global_x;
   assign rsp_ch.global_y = rsp_item.global_y;
   assign rsp_ch.global_z = rsp_item.global_z;
   assign rsp_ch.sector   = rsp_item.sector;
   assign rsp_ch.last_out = rsp_item.last_out;

`ifndef SYNTHESIS
   // an item waiting between the two halves must hold
   a_sec_hold: assert property (@(posedge clock) disable iff (reset)
      (sec_valid && !sec_ready) |=> (sec_valid && $stable(sec_item)))
      else $error("sector item changed while stalled");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_ch.valid)
      else $error("result valid right after reset");

   a_sector_range: assert property (@(posedge clock) disable iff (reset)
      rsp_ch.valid |-> ({1'b0, rsp_ch.sector} < (SECTOR_W + 1)'(NUM_SIDES)))
      else $error("sector index out of range");
`endif

endmodule
